FILE: src/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg: shared definitions for the contiguous block allocator
// Status codes, register indexes and the request action codes.
// ----------------------------------------------------------------------------
package cba_pkg;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFit    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  localparam logic RegMemSize = 1'b0;
  localparam logic RegFitMode = 1'b1;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

endpackage

FILE: src/contiguous_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator: first/best fit allocator with coalescing
// Address-ordered block table in three memories, walked by one sequencer.
// ----------------------------------------------------------------------------
// Operation: a scan reads, then compares, each entry; a split moves the rows
// above the hole up one, and a merge moves rows down, each row read, then
// written. The longest request is a best fit split at row 0.
// Throughput: one request at a time; in_ready stays low while a request is
// in work and until its result word is taken.
// Reset (async, active low): one hole of 2^ADDR_BITS units, first fit.
module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [ADDR_BITS:0]   request_size_i,
  input  logic [ADDR_BITS-1:0] free_address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_BITS-1:0] granted_address_o,
  output logic [1:0]           status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [ADDR_BITS:0]   cfg_data_i
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = ADDR_BITS + 1;
  localparam logic [SW-1:0] MemMax = SW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] CntMax = CW'(MAX_BLOCKS);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1; // read issued for idx
  localparam logic [3:0] S_CHK   = 4'd2; // read data for idx valid
  localparam logic [3:0] S_DEC   = 4'd3; // choose action after scan
  localparam logic [3:0] S_UPRD  = 4'd4; // shift up: read idx-1
  localparam logic [3:0] S_UPWR  = 4'd5; // shift up: write idx
  localparam logic [3:0] S_SPLIT = 4'd6; // write allocated front + hole rest
  localparam logic [3:0] S_FNRD  = 4'd7; // free: read next neighbor
  localparam logic [3:0] S_FNCK  = 4'd8;
  localparam logic [3:0] S_DNRD  = 4'd9; // shift down: read idx+stop
  localparam logic [3:0] S_DNWR  = 4'd10;
  localparam logic [3:0] S_MERGE = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_FNRD2 = 4'd13;

  // table memories (only rows below the count are ever read)
  logic [ADDR_BITS-1:0] mem_start [MAX_BLOCKS];
  logic [SW-1:0]        mem_size  [MAX_BLOCKS];
  logic                 mem_hole  [MAX_BLOCKS];

  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SW-1:0]        msize_q, msize_d;
  logic                 fit_q, fit_d;
  logic                 act_q;
  logic [SW-1:0]        want_q;
  logic [ADDR_BITS-1:0] faddr_q;
  logic [CW-1:0]        idx_q, idx_d;     // scan / move cursor
  logic [CW-1:0]        pick_q, pick_d;   // chosen / found row
  logic                 found_q, found_d;
  logic [SW-1:0]        best_q, best_d;
  logic [ADDR_BITS-1:0] pstart_q, pstart_d;
  logic [SW-1:0]        psize_q, psize_d;
  logic [SW-1:0]        acc_q, acc_d;     // merged size
  logic [1:0]           merge_q, merge_d; // bit0 next hole, bit1 prev hole
  logic [CW-1:0]        stop_q, stop_d;   // move distance in rows
  logic                 ovalid_q;
  logic [ADDR_BITS-1:0] oaddr_q, oaddr_d;
  logic [1:0]           ostat_q, ostat_d;
  logic                 init_q;           // table reset pending

  // memory port
  logic                 rd_en, wr_en;
  logic [IW-1:0]        rd_a, wr_a;
  logic [ADDR_BITS-1:0] rd_start, wr_start;
  logic [SW-1:0]        rd_size, wr_size;
  logic                 rd_hole, wr_hole;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[wr_a] <= wr_start;
      mem_size[wr_a]  <= wr_size;
      mem_hole[wr_a]  <= wr_hole;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_a];
      rd_size  <= mem_size[rd_a];
      rd_hole  <= mem_hole[rd_a];
    end
  end

  logic in_fire, cfg_fire, busy;
  logic [SW-1:0] cfg_ms, diff;
  logic fits;

  assign busy        = (state_q != S_IDLE) || ovalid_q || init_q;
  assign in_ready_o  = !busy;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i;
  assign out_valid_o = ovalid_q;
  assign granted_address_o = oaddr_q;
  assign status_o    = ostat_q;

  always_comb begin
    cfg_ms = cfg_data_i;
    if (cfg_ms == '0) cfg_ms = SW'(1);
    if (cfg_ms > MemMax) cfg_ms = MemMax;
  end

  assign fits = rd_hole && (rd_size >= want_q);
  assign diff = rd_size - want_q;

  always_comb begin
    state_d = state_q; count_d = count_q; msize_d = msize_q; fit_d = fit_q;
    idx_d = idx_q; pick_d = pick_q; found_d = found_q; best_d = best_q;
    pstart_d = pstart_q; psize_d = psize_q; acc_d = acc_q; merge_d = merge_q;
    stop_d = stop_q; oaddr_d = oaddr_q; ostat_d = ostat_q;
    rd_en = 1'b0; rd_a = '0; wr_en = 1'b0; wr_a = '0;
    wr_start = '0; wr_size = '0; wr_hole = 1'b0;

    if (init_q) begin
      wr_en = 1'b1; wr_size = msize_q; wr_hole = 1'b1; count_d = CW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          idx_d = '0; found_d = 1'b0; pick_d = count_q;
          if (action_i == ActAlloc && request_size_i == '0) begin
            ostat_d = StNoFit; oaddr_d = '0; state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= count_q) begin
          state_d = S_DEC;
        end else begin
          rd_en = 1'b1; rd_a = idx_q[IW-1:0]; state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_SCAN; idx_d = idx_q + CW'(1);
        if (act_q == ActFree) begin
          if (rd_start == faddr_q) begin
            found_d = 1'b1; pick_d = idx_q; state_d = S_DEC;
          end
        end else if (fits) begin
          if (!fit_q) begin
            found_d = 1'b1; pick_d = idx_q; pstart_d = rd_start;
            psize_d = rd_size; state_d = S_DEC;
          end else if (!found_q || diff < best_q) begin
            found_d = 1'b1; pick_d = idx_q; best_d = diff;
            pstart_d = rd_start; psize_d = rd_size;
            if (diff == '0) state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        oaddr_d = '0;
        if (!found_q) begin
          ostat_d = (act_q == ActFree) ? StNotFound : StNoFit;
          state_d = S_DONE;
        end else if (act_q == ActFree) begin
          // read the freed row's size; S_FNRD then marks it a hole and neighbors are read
          wr_en = 1'b1; wr_a = pick_q[IW-1:0]; wr_start = faddr_q;
          rd_en = 1'b1; rd_a = pick_q[IW-1:0];
          state_d = S_FNRD; merge_d = '0;
        end else if (psize_q == want_q) begin
          wr_en = 1'b1; wr_a = pick_q[IW-1:0]; wr_start = pstart_q;
          wr_size = psize_q; wr_hole = 1'b0;
          ostat_d = StOk; oaddr_d = pstart_q; state_d = S_DONE;
        end else if (count_q >= CntMax) begin
          ostat_d = StFull; state_d = S_DONE;
        end else begin
          idx_d = count_q; state_d = S_UPRD;
        end
      end
      S_UPRD: begin
        if (idx_q == pick_q) begin
          idx_d = pick_q + CW'(1); state_d = S_SPLIT;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q - CW'(1)); state_d = S_UPWR;
        end
      end
      S_UPWR: begin
        wr_en = 1'b1; wr_a = idx_q[IW-1:0];
        wr_start = rd_start; wr_size = rd_size; wr_hole = rd_hole;
        idx_d = idx_q - CW'(1); state_d = S_UPRD;
      end
      S_SPLIT: begin
        // idx_q == pick+1 on entry; front written first, rest next cycle
        if (idx_q == pick_q + CW'(1)) begin
          wr_en = 1'b1; wr_a = pick_q[IW-1:0]; wr_start = pstart_q;
          wr_size = want_q; wr_hole = 1'b0; idx_d = '0;
        end else begin
          wr_en = 1'b1; wr_a = IW'(pick_q + CW'(1));
          wr_start = pstart_q + want_q[ADDR_BITS-1:0];
          wr_size = psize_q - want_q; wr_hole = 1'b1;
          count_d = count_q + CW'(1);
          ostat_d = StOk; oaddr_d = pstart_q; state_d = S_DONE;
        end
      end
      S_FNRD: begin
        // size of freed block now in rd_size; write hole flag
        wr_en = 1'b1; wr_a = pick_q[IW-1:0]; wr_start = faddr_q;
        wr_size = rd_size; wr_hole = 1'b1; acc_d = rd_size;
        if (pick_q + CW'(1) < count_q) begin
          rd_en = 1'b1; rd_a = IW'(pick_q + CW'(1));
        end
        state_d = S_FNRD2;
      end
      S_FNRD2: begin
        merge_d[0] = (pick_q + CW'(1) < count_q) && rd_hole;
        psize_d = rd_size;
        if (pick_q != '0) begin
          rd_en = 1'b1; rd_a = IW'(pick_q - CW'(1));
        end
        state_d = S_FNCK;
      end
      S_FNCK: begin
        merge_d[1] = (pick_q != '0) && rd_hole;
        pstart_d = rd_start; best_d = rd_size;
        if (merge_q[0]) acc_d = acc_q + psize_q;
        state_d = S_MERGE; idx_d = '0;
      end
      S_MERGE: begin
        // write merged head, then close the gap of 0, 1 or 2 rows
        if (merge_q[1]) begin
          wr_en = 1'b1; wr_a = IW'(pick_q - CW'(1)); wr_start = pstart_q;
          wr_size = best_q + acc_q; wr_hole = 1'b1;
          idx_d = pick_q; // first row to overwrite
        end else begin
          wr_en = 1'b1; wr_a = pick_q[IW-1:0]; wr_start = faddr_q;
          wr_size = acc_q; wr_hole = 1'b1;
          idx_d = pick_q + CW'(1);
        end
        stop_d = CW'(merge_q[0]) + CW'(merge_q[1]);
        count_d = count_q - (CW'(merge_q[0]) + CW'(merge_q[1]));
        ostat_d = StOk; oaddr_d = '0;
        state_d = (merge_q == 2'b00) ? S_DONE : S_DNRD;
      end
      S_DNRD: begin
        // count_q already reduced; move rows idx+stop down to idx
        if (idx_q >= count_q) begin
          state_d = S_DONE;
        end else begin
          rd_en = 1'b1; rd_a = IW'(idx_q + stop_q); state_d = S_DNWR;
        end
      end
      S_DNWR: begin
        wr_en = 1'b1; wr_a = idx_q[IW-1:0];
        wr_start = rd_start; wr_size = rd_size; wr_hole = rd_hole;
        idx_d = idx_q + CW'(1); state_d = S_DNRD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    if (cfg_fire) begin
      if (cfg_index_i == RegMemSize) msize_d = cfg_ms;
      else fit_d = cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= CW'(1); msize_q <= MemMax; fit_q <= 1'b0;
      ovalid_q <= 1'b0; init_q <= 1'b1;
    end else begin
      state_q <= state_d; count_q <= count_d; msize_q <= msize_d;
      fit_q <= fit_d;
      init_q <= cfg_fire && (cfg_index_i == RegMemSize);
      if (state_q == S_DONE) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= action_i; want_q <= request_size_i; faddr_q <= free_address_i;
    end
    idx_q <= idx_d; pick_q <= pick_d; found_q <= found_d; best_q <= best_d;
    pstart_q <= pstart_d; psize_q <= psize_d; acc_q <= acc_d;
    merge_q <= merge_d; stop_q <= stop_d; oaddr_q <= oaddr_d;
    ostat_q <= ostat_d;
  end

endmodule

FILE: sim/tb_contiguous_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator: self-checking bench for the block allocator
// Drives allocate and free words with random gaps and output stalls. Keeps
// its own block table to work out each grant and status, and checks every
// result word in order against it.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator
  import cba_pkg::*;
();

  localparam int Blocks = 64;
  localparam int MemMax = 65536;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 3 * Blocks + 16;

  typedef struct packed {
    logic [15:0] addr;
    status_e     st;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, action;
  logic [16:0] req_size;
  logic [15:0] free_addr;
  logic        out_valid, out_ready;
  logic [15:0] granted_addr;
  logic [1:0]  status;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [16:0] cfg_data;

  contiguous_block_allocator i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .action_i          (action),
    .request_size_i    (req_size),
    .free_address_i    (free_addr),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .granted_address_o (granted_addr),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow of the block table.
  logic [15:0] blk_start [Blocks];
  logic [16:0] blk_size  [Blocks];
  logic        blk_hole  [Blocks];
  int          blk_count;
  int          mem_units;
  logic        best_fit;

  grant_t pending_grants[$];
  int     errors;
  int     cycles;
  logic   steady_sender;   // no gaps between words when set
  logic   steady_sink;     // no output stalls when set

  function automatic void table_clear();
    for (int i = 0; i < Blocks; i++) begin
      blk_start[i] = '0;
      blk_size[i]  = '0;
      blk_hole[i]  = 1'b0;
    end
    blk_size[0] = 17'(mem_units);
    blk_hole[0] = 1'b1;
    blk_count   = 1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_size[i]  = blk_size[i+1];
      blk_hole[i]  = blk_hole[i+1];
    end
    blk_count--;
  endfunction

  function automatic grant_t table_alloc(logic [16:0] want);
    grant_t      g;
    int          pick;
    logic [16:0] leftover;
    g.addr = '0;
    g.st   = StNoFit;
    pick = blk_count;
    leftover = '0;
    if (want == 0) return g;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_hole[i] || blk_size[i] < want) continue;
      if (!best_fit) begin
        pick = i;
        break;
      end
      if (pick == blk_count || blk_size[i] - want < leftover) begin
        pick = i;
        leftover = blk_size[i] - want;
        if (leftover == 0) break;
      end
    end
    if (pick >= blk_count) return g;
    if (blk_size[pick] == want) begin
      blk_hole[pick] = 1'b0;
    end else begin
      if (blk_count >= Blocks) begin
        g.st = StFull;
        return g;
      end
      for (int i = blk_count; i > pick; i--) begin
        blk_start[i] = blk_start[i-1];
        blk_size[i]  = blk_size[i-1];
        blk_hole[i]  = blk_hole[i-1];
      end
      blk_count++;
      blk_hole[pick]    = 1'b0;
      blk_size[pick]    = want;
      blk_start[pick+1] = blk_start[pick] + want[15:0];
      blk_size[pick+1]  = blk_size[pick+1] - want;
      blk_hole[pick+1]  = 1'b1;
    end
    g.addr = blk_start[pick];
    g.st   = StOk;
    return g;
  endfunction

  function automatic grant_t table_free(logic [15:0] addr);
    grant_t g;
    int     pos;
    g.addr = '0;
    g.st   = StNotFound;
    pos = blk_count;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_start[i] == addr) begin
        pos = i;
        break;
      end
    end
    if (pos >= blk_count) return g;
    blk_hole[pos] = 1'b1;
    if (pos + 1 < blk_count && blk_hole[pos+1]) begin
      blk_size[pos] += blk_size[pos+1];
      drop_entry(pos + 1);
    end
    if (pos > 0 && blk_hole[pos-1]) begin
      blk_size[pos-1] += blk_size[pos];
      drop_entry(pos);
    end
    g.st = StOk;
    return g;
  endfunction

  // Start of a live entry, allocated ones preferred.
  function automatic logic [15:0] live_start();
    int idx;
    idx = $urandom_range(0, blk_count - 1);
    for (int t = 0; t < 4 && blk_hole[idx]; t++) idx = $urandom_range(0, blk_count - 1);
    return blk_start[idx];
  endfunction

  function automatic int gap_len(logic steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic act, logic [16:0] sz, logic [15:0] fa);
    int g;
    g = gap_len(steady_sender);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    req_size  <= sz;
    free_addr <= fa;
    do @(posedge clk); while (!in_ready);
    if (act == ActAlloc) pending_grants.push_back(table_alloc(sz));
    else pending_grants.push_back(table_free(fa));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegMemSize) begin
      mem_units = (data == 0) ? 1 : ((data > MemMax) ? MemMax : int'(data));
      table_clear();
    end else begin
      best_fit = data[0];
    end
  endtask

  // Output side: random stalls unless the sink is set steady.
  int stall_left;
  always @(posedge clk) begin
    if (steady_sink) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      stall_left <= gap_len(1'b0);
      out_ready  <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: addr %0d st %0d",
                                   granted_addr, status);
      end else begin
        want = pending_grants.pop_front();
        if (granted_addr !== want.addr || status !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp addr %0d st %0d, got addr %0d st %0d",
                     want.addr, want.st, granted_addr, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Extremes of sizes and addresses, out-of-range memory sizes.
  task automatic test_extremes();
    send_word(ActAlloc, 17'd0, 16'd0);            // zero size rejected
    send_word(ActAlloc, 17'h1ffff, 16'hffff);     // larger than memory
    send_word(ActAlloc, 17'd65536, 16'd0);        // exact fit of all memory
    send_word(ActAlloc, 17'd1, 16'd0);            // nothing left
    send_word(ActFree, 17'd0, 16'hffff);          // unknown address
    send_word(ActFree, 17'h1ffff, 16'd0);
    send_word(ActFree, 17'd0, 16'd0);             // freeing a hole
    write_reg(RegMemSize, 17'd0);                 // taken as one unit
    send_word(ActAlloc, 17'd2, 16'd0);
    send_word(ActAlloc, 17'd1, 16'd0);
    write_reg(RegMemSize, 17'h1ffff);             // clamped to full range
    send_word(ActAlloc, 17'd65535, 16'd0);
    send_word(ActAlloc, 17'd1, 16'd0);
    send_word(ActFree, 17'd0, 16'd65535);
  endtask

  // Three holes of 10, 5 and 35: first fit and best fit pick differently.
  task automatic test_fit_modes(logic mode);
    write_reg(RegMemSize, 17'd100);
    write_reg(RegFitMode, {16'd0, mode});
    send_word(ActAlloc, 17'd10, 16'd0);
    send_word(ActAlloc, 17'd20, 16'd0);
    send_word(ActAlloc, 17'd5, 16'd0);
    send_word(ActAlloc, 17'd30, 16'd0);
    send_word(ActFree, 17'd0, 16'd0);
    send_word(ActFree, 17'd0, 16'd30);
    send_word(ActAlloc, 17'd5, 16'd0);
    send_word(ActAlloc, 17'd4, 16'd0);
    send_word(ActFree, 17'd0, 16'd10);            // merges on both sides in first fit mode
    send_word(ActFree, 17'd0, 16'd35);
  endtask

  // Fill the table with unit blocks: a split is then refused, exact fit not.
  task automatic test_table_full();
    write_reg(RegMemSize, 17'd1000);
    write_reg(RegFitMode, {16'd0, 1'b0});
    for (int i = 0; i < Blocks; i++) send_word(ActAlloc, 17'd1, 16'd0);
    send_word(ActAlloc, 17'd2, 16'd0);
    send_word(ActAlloc, 17'd937, 16'd0);
    for (int i = 0; i < Blocks; i += 2) send_word(ActFree, 17'd0, 16'(i));
  endtask

  task automatic test_random(int n_words);
    int          done;
    int          r;
    logic [16:0] sz;
    done = 0;
    while (done < n_words) begin
      r = $urandom_range(0, 9);
      write_reg(RegMemSize, (r == 0) ? 17'd65536 : 17'($urandom_range(40, 400)));
      write_reg(RegFitMode, 17'($urandom_range(0, 1)));
      steady_sender = ($urandom_range(0, 3) == 0);
      steady_sink   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 150; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) wait_drained();                // let the pipe run dry
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_word(ActAlloc, 17'($urandom_range(0, 17'h1ffff)), 16'($urandom));
        end else if (r < 8) begin
          send_word(ActFree, 17'($urandom), 16'($urandom_range(0, 16'hffff)));
        end else if (r < 55) begin
          sz = 17'($urandom_range(1, (mem_units > 2048) ? 2048 : mem_units / 6 + 1));
          send_word(ActAlloc, sz, 16'($urandom));
        end else begin
          send_word(ActFree, 17'($urandom), live_start());
        end
        done++;
      end
    end
    steady_sender = 1'b0;
    steady_sink   = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = ActAlloc;
    req_size = '0;
    free_addr = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegMemSize;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    steady_sender = 1'b0;
    steady_sink = 1'b0;
    mem_units = MemMax;
    best_fit = 1'b0;
    table_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_fit_modes(1'b0);
    test_fit_modes(1'b1);
    test_table_full();
    test_random(1800);

    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cba_pkg.sv
src/contiguous_block_allocator.sv
sim/tb_contiguous_block_allocator.sv
